// File: rtl/fwrs_pkg.sv
package fwrs_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 7;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// File: rtl/fifo_with_run_and_sum_stats.sv
// Steps: push runs S_PUSH_CMP, S_PUSH_ADD, S_DONE; pop runs S_RD_HEAD,
//   S_RD_NEXT, S_POP_SUB, S_DONE; peek skips S_POP_SUB; clear and error
//   requests go straight to S_DONE, which holds while the last output word
//   is not yet taken. One request at a time, set by the single shared adder
//   and the one read port of the value store.
// Reset (arst_n low, async): queue empty, indices, sum and run state zero,
//   no output word pending. Store contents are not cleared.
module fifo_with_run_and_sum_stats import fwrs_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [WORD_W-1:0] push_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] head_value,
	output logic [1:0]        status,
	output logic [CNT_W-1:0]  entry_count,
	output logic [WORD_W-1:0] content_sum,
	output logic [CNT_W-1:0]  run_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int RW = WORD_W + 1;	// flip mark + value

	// Run tracking: each stored entry carries a flip mark, set when the
	// comparison of its pair with the entry before differs from the pair
	// before that. Runs = flips among entries at queue position 3 and up,
	// plus one. Popping the head drops the mark of the entry at position 3.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_CMP,
		S_PUSH_ADD,
		S_RD_HEAD,
		S_RD_NEXT,
		S_POP_SUB,
		S_DONE
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [WORD_W-1:0] val_q;
	logic [AW-1:0]     rd_idx_q;
	logic [AW-1:0]     wr_idx_q;
	logic [CW-1:0]     held_q;
	logic [CW-1:0]     flips_q;
	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] last_q;	// tail value
	logic              last_dir_q;	// comparison of the tail pair
	logic [WORD_W-1:0] head_q;
	status_t           res_status_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] out_head_q;
	logic [1:0]        out_status_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [WORD_W-1:0] out_sum_q;
	logic [CNT_W-1:0]  out_runs_q;

	alu_op_t           alu_op;
	logic [WORD_W-1:0] alu_a;
	logic [WORD_W-1:0] alu_b;
	logic [WORD_W-1:0] alu_res;
	logic              alu_le;

	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	logic [RW-1:0]     ram_rdata;
	logic              flip_new;

	logic [CW+CNT_W-1:0] count_x;
	logic [CW+CNT_W:0]   runs_x;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	// shared unit operand select
	always_comb begin
		unique case (state_q)
			S_PUSH_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = last_q;
				alu_b  = val_q;
			end
			S_POP_SUB: begin
				alu_op = ALU_SUB;
				alu_a  = sum_q;
				alu_b  = head_q;
			end
			default: begin
				alu_op = ALU_ADD;
				alu_a  = sum_q;
				alu_b  = val_q;
			end
		endcase
	end

	fwrs_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.le  (alu_le)
	);

	assign ram_we    = (state_q == S_PUSH_CMP);
	assign ram_raddr = (state_q == S_RD_NEXT) ? idx_inc(idx_inc(rd_idx_q)) : rd_idx_q;
	assign flip_new  = (held_q >= CW'(2)) && (alu_le != last_dir_q);

	fwrs_ram #(
		.WIDTH (RW),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_idx_q),
		.wdata ({flip_new, val_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign count_x = {{CNT_W{1'b0}}, held_q};
	assign runs_x  = (held_q == '0) ? '0 : {{(CNT_W+1){1'b0}}, flips_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= REQ_PUSH;
			val_q        <= '0;
			rd_idx_q     <= '0;
			wr_idx_q     <= '0;
			held_q       <= '0;
			flips_q      <= '0;
			sum_q        <= '0;
			last_q       <= '0;
			last_dir_q   <= 1'b0;
			head_q       <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= req_t'(req_type);
						val_q        <= push_value;
						head_q       <= '0;
						res_status_q <= ST_OK;
						unique case (req_t'(req_type))
							REQ_PUSH: begin
								if (held_q == CW'(QUEUE_DEPTH)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_PUSH_CMP;
								end
							end
							REQ_POP, REQ_PEEK: begin
								if (held_q == '0) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_RD_HEAD;
								end
							end
							REQ_CLEAR: begin
								rd_idx_q <= '0;
								wr_idx_q <= '0;
								held_q   <= '0;
								flips_q  <= '0;
								sum_q    <= '0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_PUSH_CMP: begin
					last_dir_q <= alu_le;
					last_q     <= val_q;
					flips_q    <= flips_q + {{(CW-1){1'b0}}, flip_new};
					wr_idx_q   <= idx_inc(wr_idx_q);
					held_q     <= held_q + 1'b1;
					state_q    <= S_PUSH_ADD;
				end
				S_PUSH_ADD: begin
					sum_q   <= alu_res;
					state_q <= S_DONE;
				end
				S_RD_HEAD: begin
					state_q <= S_RD_NEXT;
				end
				S_RD_NEXT: begin
					head_q  <= ram_rdata[WORD_W-1:0];
					state_q <= (req_q == REQ_PEEK) ? S_DONE : S_POP_SUB;
				end
				S_POP_SUB: begin
					// entry at position 3 moves to position 2: its mark no longer counts
					flips_q  <= flips_q - {{(CW-1){1'b0}},
						((held_q >= CW'(3)) && ram_rdata[WORD_W])};
					sum_q    <= alu_res;
					rd_idx_q <= idx_inc(rd_idx_q);
					held_q   <= held_q - 1'b1;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output word, loaded when the request finishes
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_head_q   <= head_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_x[CNT_W-1:0];
			out_sum_q    <= sum_q;
			out_runs_q   <= runs_x[CNT_W-1:0];
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign head_value  = out_head_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign content_sum = out_sum_q;
	assign run_count   = out_runs_q;

endmodule

// File: rtl/fwrs_ram.sv
module fwrs_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/fwrs_alu.sv
// Shared add/subtract unit; subtract also yields signed a <= b.
module fwrs_alu import fwrs_pkg::*; (
	input  alu_op_t           op,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] res,
	output logic              le
);

	logic [WORD_W:0] a_x;
	logic [WORD_W:0] b_x;
	logic [WORD_W:0] r_x;

	assign a_x = {a[WORD_W-1], a};
	assign b_x = (op == ALU_SUB) ? ~{b[WORD_W-1], b} : {b[WORD_W-1], b};
	assign r_x = a_x + b_x + {{WORD_W{1'b0}}, (op == ALU_SUB)};
	assign res = r_x[WORD_W-1:0];
	// a - b <= 0 in 33-bit signed form
	assign le  = r_x[WORD_W] || (r_x == '0);

endmodule

// File: tb/sv/fifo_with_run_and_sum_stats_test.sv
module fifo_with_run_and_sum_stats_test;
	import fwrs_pkg::*;

	localparam int DEPTH          = 64;
	localparam int RANDOM_WORDS   = 800;
	localparam int IDLE_PCT       = 17;     // chance in 100 that a side idles in a cycle
	localparam int RX_HOLD_CYCLES = 300;    // long output hold-off, fills the pipe and backs up in_ready
	localparam int DRAIN_LIMIT    = 20000;  // cycles allowed for the last words to come out
	localparam int SETTLE_CYCLES  = 16;     // quiet at the end to catch stray words
	localparam int MAX_REPORTS    = 10;

	// One result word as it leaves the block.
	typedef struct {
		logic [WORD_W-1:0] head;
		logic [1:0]        st;
		logic [CNT_W-1:0]  cnt;
		logic [WORD_W-1:0] sum;
		logic [CNT_W-1:0]  runs;
	} fifo_word_t;

	// How push values are chosen within a phase; ramps and zigzags steer the run count.
	typedef enum int {VS_RANDOM, VS_NARROW, VS_RISE, VS_FALL, VS_ZIGZAG, VS_EXTREME} value_style_t;
	// Request mix of a phase: mostly pushes, mostly pops, or even.
	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

	// Shadow queue: mirrors the block's store, indices and running sum, and keeps
	// the result words still owed by the block in request order.
	class fifo_scoreboard;
		logic [WORD_W-1:0] store [DEPTH];
		int                rd_idx, wr_idx, held;
		logic [WORD_W-1:0] sum;
		fifo_word_t        owed_q[$];
		int                errors, checked;
		int                n_push, n_full, n_empty, n_clear, peak_runs;

		function new();
			rd_idx = 0;
			wr_idx = 0;
			held = 0;
			sum = '0;
			errors = 0;
			checked = 0;
			n_push = 0;
			n_full = 0;
			n_empty = 0;
			n_clear = 0;
			peak_runs = 0;
		endfunction

		// A run boundary falls wherever the signed a <= b test of a neighbor pair
		// differs from that of the pair before it.
		function int count_runs();
			int runs, k;
			bit dir, c;
			if (held == 0)
				return 0;
			if (held == 1)
				return 1;
			runs = 1;
			dir = $signed(store[rd_idx]) <= $signed(store[(rd_idx + 1) % DEPTH]);
			for (k = 1; k + 1 < held; k++) begin
				c = $signed(store[(rd_idx + k) % DEPTH]) <= $signed(store[(rd_idx + k + 1) % DEPTH]);
				if (c != dir) begin
					runs++;
					dir = c;
				end
			end
			return runs;
		endfunction

		// Apply one accepted request and queue the word it must produce.
		function void note_request(req_t req, logic [WORD_W-1:0] val);
			fifo_word_t w;
			int r;
			w.head = '0;
			w.st = ST_OK;
			case (req)
				REQ_PUSH: begin
					if (held >= DEPTH) begin
						w.st = ST_FULL;
						n_full++;
					end else begin
						store[wr_idx] = val;
						wr_idx = (wr_idx + 1) % DEPTH;
						held++;
						sum += val;
						n_push++;
					end
				end
				REQ_POP: begin
					if (held == 0) begin
						w.st = ST_EMPTY;
						n_empty++;
					end else begin
						w.head = store[rd_idx];
						rd_idx = (rd_idx + 1) % DEPTH;
						held--;
						sum -= w.head;
					end
				end
				REQ_PEEK: begin
					if (held == 0) begin
						w.st = ST_EMPTY;
						n_empty++;
					end else begin
						w.head = store[rd_idx];
					end
				end
				default: begin
					rd_idx = 0;
					wr_idx = 0;
					held = 0;
					sum = '0;
					n_clear++;
				end
			endcase
			r = count_runs();
			if (r > peak_runs)
				peak_runs = r;
			w.cnt = CNT_W'(held);
			w.sum = sum;
			w.runs = CNT_W'(r);
			owed_q.push_back(w);
		endfunction

		function void check_word(fifo_word_t got);
			fifo_word_t want;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected word: head %h st %0d cnt %0d sum %h runs %0d",
						got.head, got.st, got.cnt, got.sum, got.runs);
				return;
			end
			want = owed_q.pop_front();
			checked++;
			if (got.head !== want.head || got.st !== want.st || got.cnt !== want.cnt ||
					got.sum !== want.sum || got.runs !== want.runs) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("mismatch on word %0d", checked);
					$display("  expected head %h st %0d cnt %0d sum %h runs %0d",
						want.head, want.st, want.cnt, want.sum, want.runs);
					$display("  actual   head %h st %0d cnt %0d sum %h runs %0d",
						got.head, got.st, got.cnt, got.sum, got.runs);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        req_type;
	logic [WORD_W-1:0] push_value;
	logic              out_valid;
	logic              out_ready;
	logic [WORD_W-1:0] head_value;
	logic [1:0]        status;
	logic [CNT_W-1:0]  entry_count;
	logic [WORD_W-1:0] content_sum;
	logic [CNT_W-1:0]  run_count;

	fifo_scoreboard    sb;

	// Stimulus state; calm and stall_rx are shared by the sender and the receiver.
	bit                calm;       // no idling on either side while set
	bit                stall_rx;   // asks the receiver for its long hold-off
	logic [WORD_W-1:0] ramp_val;
	bit                zig;

	fifo_with_run_and_sum_stats #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head_value(head_value),
		.status(status),
		.entry_count(entry_count),
		.content_sum(content_sum),
		.run_count(run_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

	// Next push value for the given style. Ramps step by 0..3 so equal neighbors
	// (a <= b true both ways) show up; zigzag flips direction on every entry.
	function logic [WORD_W-1:0] pick_value(value_style_t vs);
		int t;
		case (vs)
			VS_NARROW: begin
				t = int'($urandom_range(8)) - 4;
				return t;
			end
			VS_RISE: begin
				ramp_val += $urandom_range(3);
				return ramp_val;
			end
			VS_FALL: begin
				ramp_val -= $urandom_range(3);
				return ramp_val;
			end
			VS_ZIGZAG: begin
				zig = !zig;
				return zig ? ramp_val + $urandom_range(1000, 1) : ramp_val - $urandom_range(1000, 1);
			end
			VS_EXTREME: begin
				case ($urandom_range(4))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function req_t pick_req(phase_kind_t pk);
		int r;
		r = $urandom_range(99);
		case (pk)
			PH_FILL: begin
				if (r < 2) return REQ_CLEAR;
				if (r < 80) return REQ_PUSH;
				if (r < 90) return REQ_POP;
				return REQ_PEEK;
			end
			PH_DRAIN: begin
				if (r < 2) return REQ_CLEAR;
				if (r < 17) return REQ_PUSH;
				if (r < 82) return REQ_POP;
				return REQ_PEEK;
			end
			default: begin
				if (r < 3) return REQ_CLEAR;
				if (r < 45) return REQ_PUSH;
				if (r < 80) return REQ_POP;
				return REQ_PEEK;
			end
		endcase
	endfunction

	// Offer one word at a falling edge, after a random idle gap, and hold it
	// until the block takes it at a rising edge. Valid is only lowered when the
	// gap actually happens, so back-to-back words keep it high.
	task automatic send_word(input req_t req, input logic [WORD_W-1:0] val);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = req;
		push_value = val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(req, val);
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off on request.
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_rx) begin
				stall_rx = 1'b0;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (calm) begin
				out_ready = 1'b1;
			end else begin
				out_ready = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Result monitor: outputs sampled at the rising edge, before the block updates.
	always @(posedge clk) begin : rx_mon
		fifo_word_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.head = head_value;
			seen.st = status;
			seen.cnt = entry_count;
			seen.sum = content_sum;
			seen.runs = run_count;
			sb.check_word(seen);
		end
	end

	initial begin : stimulus
		int n_random, j, len, waited;
		bit hold_done;
		phase_kind_t pk;
		value_style_t vs;

		sb = new();
		calm = 1'b0;
		stall_rx = 1'b0;
		ramp_val = $urandom;
		zig = 1'b0;
		hold_done = 1'b0;
		n_random = 0;
		in_valid = 1'b0;
		req_type = REQ_PUSH;
		push_value = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: errors on an empty queue, clear while empty, extreme values,
		// equal neighbors, sum wrap in both directions, clear while holding data.
		send_word(REQ_PEEK, 32'h1234_5678);
		send_word(REQ_POP, 32'hffff_ffff);
		send_word(REQ_CLEAR, 32'h0);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_PUSH, 32'h7fff_ffff);
		send_word(REQ_PUSH, 32'h7fff_ffff);
		send_word(REQ_PUSH, 32'h0000_0000);
		send_word(REQ_PUSH, 32'hffff_ffff);
		send_word(REQ_PUSH, 32'hffff_ffff);
		send_word(REQ_PUSH, 32'h0000_0001);
		send_word(REQ_PEEK, 32'h0);
		send_word(REQ_POP, 32'h0);
		send_word(REQ_POP, 32'h0);
		send_word(REQ_PEEK, 32'h0);
		send_word(REQ_CLEAR, 32'hdead_beef);
		send_word(REQ_PEEK, 32'h0);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_PUSH, 32'h8000_0000);
		send_word(REQ_POP, 32'h0);
		send_word(REQ_POP, 32'h0);
		send_word(REQ_POP, 32'h0);

		// Fill to the top with a zigzag (most runs possible), push into the full
		// queue, then drain past empty. Indices end up away from zero.
		while (sb.held < DEPTH) begin
			send_word(REQ_PUSH, pick_value(VS_ZIGZAG));
			n_random++;
		end
		repeat (3) begin
			send_word(REQ_PUSH, $urandom);
			n_random++;
		end
		while (sb.held > 0) begin
			send_word(n_random % 3 ? REQ_POP : REQ_PEEK, $urandom);
			n_random++;
		end
		repeat (2) begin
			send_word(REQ_POP, $urandom);
			n_random++;
		end

		// Random phases of biased request mixes and value styles.
		while (n_random < RANDOM_WORDS) begin
			pk = phase_kind_t'($urandom_range(2));
			vs = value_style_t'($urandom_range(5));
			len = $urandom_range(90, 10);
			if (n_random >= 250 && !hold_done) begin
				// long receiver hold-off while the sender keeps pushing
				pk = PH_FILL;
				stall_rx = 1'b1;
				hold_done = 1'b1;
			end
			calm = (n_random >= 450 && n_random < 580);
			for (j = 0; j < len && n_random < RANDOM_WORDS; j++) begin
				send_word(pick_req(pk), pick_value(vs));
				n_random++;
			end
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid = 1'b0;

		// Wait out the owed words, then a short quiet spell to catch stray ones.
		waited = 0;
		while (sb.owed_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.owed_q.size() != 0) begin
			$display("%0d result words never arrived", sb.owed_q.size());
			sb.errors += sb.owed_q.size();
		end

		$display("%0d words checked: %0d values stored, %0d pushes refused when full,",
			sb.checked, sb.n_push, sb.n_full);
		$display("%0d pops or peeks on an empty queue, %0d clears, up to %0d runs; %0d errors",
			sb.n_empty, sb.n_clear, sb.peak_runs, sb.errors);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: fifo_with_run_and_sum_stats.f
rtl/fwrs_pkg.sv
rtl/fwrs_ram.sv
rtl/fwrs_alu.sv
rtl/fifo_with_run_and_sum_stats.sv
tb/sv/fifo_with_run_and_sum_stats_test.sv
